>>> hdl/hlfp_pkg.sv
`default_nettype none

package hlfp_pkg;

    // frame header bytes
    localparam logic [7:0] HEAD_FIRST  = 8'hAA;
    localparam logic [7:0] HEAD_SECOND = 8'hAF;

    // function byte must lie below this code and above zero
    localparam logic [7:0] FUNC_END    = 8'hF1;

    // payload starts after the two header bytes, function and length
    localparam int HEAD_BYTES  = 4;

    // header plus trailing byte
    localparam int FRAME_EXTRA = 5;

endpackage

`default_nettype wire

>>> hdl/hlfp_ram.sv
`default_nettype none

module hlfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 54
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/hlfp_parser.sv
`default_nettype none

module hlfp_parser
    import hlfp_pkg::*;
#(
    parameter int LENGTH_LIMIT = 50
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_fire,
    input  wire logic [7:0]                            rx_byte,
    output logic                                       wr_en,
    output logic [$clog2(LENGTH_LIMIT+4)-1:0]          wr_addr,
    output logic [7:0]                                 wr_data,
    output logic                                       start,
    output logic [$clog2(LENGTH_LIMIT+5)-1:0]          start_total
);

    localparam int DEPTH  = LENGTH_LIMIT + 4;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int CNT_W  = $clog2(LENGTH_LIMIT);
    localparam logic [7:0] LIMIT_BYTE = 8'(LENGTH_LIMIT);

    typedef enum logic [2:0] {
        IDLE,
        GOT_FIRST,
        GOT_SECOND,
        GOT_FUNC,
        PAYLOAD,
        TRAILER
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // next phase, store write and frame start
    always_comb
    begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        count_next  = count_reg;
        wr_en       = 1'b0;
        wr_addr     = ADDR_W'(HEAD_BYTES) + ADDR_W'(count_reg);
        wr_data     = rx_byte;
        start       = 1'b0;
        start_total = LEN_W'(count_reg) + LEN_W'(FRAME_EXTRA);
        if (in_fire)
        begin
            phase_next = IDLE;
            unique case (phase_reg)
                IDLE:
                begin
                    if (rx_byte == HEAD_FIRST)
                    begin
                        phase_next = GOT_FIRST;
                        wr_en      = 1'b1;
                        wr_addr    = ADDR_W'(0);
                    end
                end
                GOT_FIRST:
                begin
                    if (rx_byte == HEAD_SECOND)
                    begin
                        phase_next = GOT_SECOND;
                        wr_en      = 1'b1;
                        wr_addr    = ADDR_W'(1);
                    end
                end
                GOT_SECOND:
                begin
                    if (rx_byte != 8'd0 && rx_byte < FUNC_END)
                    begin
                        phase_next = GOT_FUNC;
                        wr_en      = 1'b1;
                        wr_addr    = ADDR_W'(2);
                    end
                end
                GOT_FUNC:
                begin
                    if (rx_byte < LIMIT_BYTE)
                    begin
                        phase_next  = PAYLOAD;
                        wr_en       = 1'b1;
                        wr_addr     = ADDR_W'(3);
                        remain_next = CNT_W'(rx_byte);
                        count_next  = '0;
                    end
                end
                PAYLOAD:
                begin
                    // zero length drops out here without completing
                    if (remain_reg != '0)
                    begin
                        wr_en       = 1'b1;
                        remain_next = remain_reg - CNT_W'(1);
                        count_next  = count_reg + CNT_W'(1);
                        phase_next  = (remain_reg == CNT_W'(1)) ? TRAILER : PAYLOAD;
                    end
                end
                TRAILER:
                begin
                    wr_en = 1'b1;
                    start = 1'b1;
                end
                default:
                begin
                    phase_next = IDLE;
                end
            endcase
        end
    end

    // phase and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= IDLE;
            remain_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/hlfp_emitter.sv
`default_nettype none

module hlfp_emitter #(
    parameter int LENGTH_LIMIT = 50
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [$clog2(LENGTH_LIMIT+5)-1:0]  start_total,
    output logic                                    rd_en,
    output logic [$clog2(LENGTH_LIMIT+4)-1:0]       rd_addr,
    input  wire logic [7:0]                         rd_data,
    output logic                                    busy,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [7:0]                              frame_byte,
    output logic [$clog2(LENGTH_LIMIT+4)-1:0]       byte_position,
    output logic [$clog2(LENGTH_LIMIT+5)-1:0]       frame_length,
    output logic                                    last_byte
);

    localparam int DEPTH  = LENGTH_LIMIT + 4;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);

    logic              busy_reg;
    logic              issuing_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [LEN_W-1:0]  total_reg;
    logic              rd_vld_reg;
    logic [ADDR_W-1:0] rd_pos_reg;
    logic              out_valid_reg;
    logic [7:0]        frame_byte_reg;
    logic [ADDR_W-1:0] byte_position_reg;
    logic [LEN_W-1:0]  frame_length_reg;
    logic              last_byte_reg;

    logic advance;
    logic load;
    logic issue;
    logic last_issue;
    logic out_done;

    // read stage feeds the output register, one byte per cycle when not stalled
    assign advance    = !out_valid_reg || out_ready;
    assign load       = rd_vld_reg && advance;
    assign issue      = issuing_reg && (!rd_vld_reg || load);
    assign last_issue = (LEN_W'(addr_reg) + LEN_W'(1)) == total_reg;
    assign out_done   = out_valid_reg && out_ready && last_byte_reg;

    assign rd_en   = issue;
    assign rd_addr = addr_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            issuing_reg   <= 1'b0;
            addr_reg      <= '0;
            total_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                busy_reg    <= 1'b1;
                issuing_reg <= 1'b1;
                addr_reg    <= '0;
                total_reg   <= start_total;
            end
            else
            begin
                if (out_done)
                begin
                    busy_reg <= 1'b0;
                end
                if (issue)
                begin
                    addr_reg <= addr_reg + ADDR_W'(1);
                    if (last_issue)
                    begin
                        issuing_reg <= 1'b0;
                    end
                end
            end
            if (issue)
            begin
                rd_vld_reg <= 1'b1;
            end
            else if (load)
            begin
                rd_vld_reg <= 1'b0;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // read position and output payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_pos_reg <= addr_reg;
        end
        if (load)
        begin
            frame_byte_reg    <= rd_data;
            byte_position_reg <= rd_pos_reg;
            frame_length_reg  <= total_reg;
            last_byte_reg     <= (LEN_W'(rd_pos_reg) + LEN_W'(1)) == total_reg;
        end
    end

    assign busy          = busy_reg;
    assign out_valid     = out_valid_reg;
    assign frame_byte    = frame_byte_reg;
    assign byte_position = byte_position_reg;
    assign frame_length  = frame_length_reg;
    assign last_byte     = last_byte_reg;

endmodule

`default_nettype wire

>>> hdl/header_length_frame_parser.sv
// Frame parser for a received byte stream. Frames are 0xAA, 0xAF, a function
// byte from 0x01 to 0xF0, a length byte below LENGTH_LIMIT, that many payload
// bytes and one unchecked trailing byte. A byte that breaks the pattern sends
// the parser back to idle and is dropped; a zero-length frame never completes.
// Every frame byte is written into a frame buffer of LENGTH_LIMIT+4 entries; on the
// trailing byte the buffer is played out, header first, one transfer per byte
// with its position, the frame length (payload + 5) and last_byte on the final
// byte. While parsing, one byte is taken each cycle. After the trailing byte
// is taken and until the last output byte is transferred, in_ready is low;
// playout reads the buffer through its single, registered read port.

`default_nettype none

module header_length_frame_parser
    import hlfp_pkg::*;
#(
    parameter int LENGTH_LIMIT = 50
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [7:0]                         rx_byte,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [7:0]                              frame_byte,
    output logic [$clog2(LENGTH_LIMIT+4)-1:0]       byte_position,
    output logic [$clog2(LENGTH_LIMIT+5)-1:0]       frame_length,
    output logic                                    last_byte
);

    localparam int DEPTH  = LENGTH_LIMIT + 4;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);

    logic              in_fire;
    logic              busy;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              start;
    logic [LEN_W-1:0]  start_total;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // input transfer only while no frame is being played out
    assign in_ready = !busy;
    assign in_fire  = in_valid && in_ready;

    // header and length checks, buffer writes
    hlfp_parser #(
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .rx_byte     (rx_byte),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .start       (start),
        .start_total (start_total)
    );

    // frame buffer
    hlfp_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // frame playout
    hlfp_emitter #(
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .start_total   (start_total),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .busy          (busy),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .frame_length  (frame_length),
        .last_byte     (last_byte)
    );

    // first two bytes of a played out frame are the header
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_position == ADDR_W'(0) |-> frame_byte == HEAD_FIRST)
        else $error("frame does not start with first header byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_position == ADDR_W'(1) |-> frame_byte == HEAD_SECOND)
        else $error("second frame byte is not the second header byte");

    // last marker sits on the final position
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_byte |-> LEN_W'(byte_position) + LEN_W'(1) == frame_length)
        else $error("last_byte not on final frame position");

    // no input taken while a frame is being played out
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted during frame playout");

endmodule

`default_nettype wire

>>> verif/header_length_frame_parser_tb.sv
module header_length_frame_parser_tb;
    import hlfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LENGTH_LIMIT = 50;
    localparam int STORE_DEPTH  = LENGTH_LIMIT + HEAD_BYTES;
    localparam int POS_W        = $clog2(LENGTH_LIMIT + 4);
    localparam int LEN_W        = $clog2(LENGTH_LIMIT + 5);
    localparam int ITEM_TARGET  = 170;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 300000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_GOT_FIRST,
        PH_GOT_SECOND,
        PH_GOT_FUNC,
        PH_PAYLOAD,
        PH_TRAILER
    } parse_phase_t;

    typedef struct {
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        logic             last;
    } frame_beat_t;

    // tracks the parser and holds the frame bytes still to be played out
    class frame_scoreboard;
        parse_phase_t phase;
        int unsigned  remaining;
        int unsigned  payload_cnt;
        logic [7:0]   store [0:STORE_DEPTH-1];
        frame_beat_t  pending_beats [$];
        int           errors;

        function new();
            phase       = PH_IDLE;
            remaining   = 0;
            payload_cnt = 0;
            errors      = 0;
        endfunction

        // advance the parser on one accepted byte
        function void note_byte(logic [7:0] b);
            int unsigned total;
            frame_beat_t beat;
            case (phase)
                PH_IDLE:
                begin
                    if (b == HEAD_FIRST)
                    begin
                        store[0] = b;
                        phase = PH_GOT_FIRST;
                    end
                end
                PH_GOT_FIRST:
                begin
                    if (b == HEAD_SECOND)
                    begin
                        store[1] = b;
                        phase = PH_GOT_SECOND;
                    end
                    else
                        phase = PH_IDLE;
                end
                PH_GOT_SECOND:
                begin
                    if (b > 8'h00 && b < FUNC_END)
                    begin
                        store[2] = b;
                        phase = PH_GOT_FUNC;
                    end
                    else
                        phase = PH_IDLE;
                end
                PH_GOT_FUNC:
                begin
                    if (b < LENGTH_LIMIT)
                    begin
                        store[3] = b;
                        remaining = b;
                        payload_cnt = 0;
                        phase = PH_PAYLOAD;
                    end
                    else
                        phase = PH_IDLE;
                end
                PH_PAYLOAD:
                begin
                    // a zero length frame falls out here on its next byte
                    if (remaining > 0)
                    begin
                        store[HEAD_BYTES + payload_cnt] = b;
                        payload_cnt++;
                        remaining--;
                        if (remaining == 0)
                            phase = PH_TRAILER;
                    end
                    else
                        phase = PH_IDLE;
                end
                PH_TRAILER:
                begin
                    store[HEAD_BYTES + payload_cnt] = b;
                    total = payload_cnt + FRAME_EXTRA;
                    for (int k = 0; k < total; k++)
                    begin
                        beat.data = store[k];
                        beat.pos  = POS_W'(k);
                        beat.len  = LEN_W'(total);
                        beat.last = (k + 1 == total);
                        pending_beats.push_back(beat);
                    end
                    phase = PH_IDLE;
                end
                default:
                    phase = PH_IDLE;
            endcase
        endfunction

        function void compare_field(string name, int expected, int actual);
            if (expected != actual)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, expected, actual);
                errors++;
            end
        endfunction

        // compare one output transfer against the oldest expected byte
        function void check_beat(logic [7:0] data, logic [POS_W-1:0] pos,
                                 logic [LEN_W-1:0] len, logic last);
            frame_beat_t exp_beat;
            if (pending_beats.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual %0h pos %0d len %0d",
                         $time, data, pos, len);
                errors++;
            end
            else
            begin
                exp_beat = pending_beats.pop_front();
                compare_field("frame_byte", exp_beat.data, data);
                compare_field("byte_position", exp_beat.pos, pos);
                compare_field("frame_length", exp_beat.len, len);
                compare_field("last_byte", exp_beat.last, last);
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [7:0]       rx_byte = 8'h00;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [7:0]       frame_byte;
    logic [POS_W-1:0] byte_position;
    logic [LEN_W-1:0] frame_length;
    logic             last_byte;

    frame_scoreboard sb;
    int              gap_pct = 0;
    int              stall_pct = 0;
    int              bytes_sent = 0;
    int              cycle_count = 0;

    header_length_frame_parser #(
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .frame_length  (frame_length),
        .last_byte     (last_byte)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("header_length_frame_parser regression: fail");
            $finish;
        end
    end

    // random output stalls
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // outputs settle mid-cycle, a transfer seen here completes at the next edge
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat(frame_byte, byte_position, frame_length, last_byte);
    end

    // present one byte, return at the edge that takes it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] func, input logic [7:0] len);
        send_byte(HEAD_FIRST);
        send_byte(HEAD_SECOND);
        send_byte(func);
        send_byte(len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
    endtask

    // header that breaks off at a random point
    task automatic send_broken_header();
        int         cut;
        logic [7:0] bad;
        cut = $urandom_range(0, 3);
        send_byte(HEAD_FIRST);
        case (cut)
            0:
            begin
                bad = 8'($urandom_range(0, 255));
                if (bad == HEAD_SECOND)
                    bad = 8'h00;
                send_byte(bad);
            end
            1:
            begin
                send_byte(HEAD_SECOND);
                if ($urandom_range(0, 1))
                    send_byte(8'h00);
                else
                    send_byte(8'($urandom_range(FUNC_END, 255)));
            end
            2:
            begin
                send_byte(HEAD_SECOND);
                send_byte(8'($urandom_range(1, FUNC_END - 1)));
                send_byte(8'($urandom_range(LENGTH_LIMIT, 255)));
            end
            default:
            begin
                // zero length, the next byte drops the frame
                send_byte(HEAD_SECOND);
                send_byte(8'($urandom_range(1, FUNC_END - 1)));
                send_byte(8'h00);
                send_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic send_random_item();
        int         pick;
        logic [7:0] func;
        logic [7:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            case ($urandom_range(0, 9))
                0: func = 8'h01;
                1: func = 8'(FUNC_END - 1);
                default: func = 8'($urandom_range(1, FUNC_END - 1));
            endcase
            // mostly short frames, a few long ones
            if ($urandom_range(0, 99) < 88)
                len = 8'($urandom_range(1, 8));
            else
                len = 8'($urandom_range(9, LENGTH_LIMIT - 1));
            send_frame(func, len);
        end
        else if (pick < 85)
            send_broken_header();
        else
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_for_drain();
        while (sb.pending_beats.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: a repeated first header byte is dropped, not rechecked
        send_byte(HEAD_FIRST);
        send_byte(HEAD_FIRST);
        send_byte(HEAD_SECOND);
        // function byte of zero and one past the top
        send_byte(HEAD_FIRST);
        send_byte(HEAD_SECOND);
        send_byte(8'h00);
        send_byte(HEAD_FIRST);
        send_byte(HEAD_SECOND);
        send_byte(FUNC_END);
        // length at the limit
        send_byte(HEAD_FIRST);
        send_byte(HEAD_SECOND);
        send_byte(8'h01);
        send_byte(8'(LENGTH_LIMIT));
        // zero length never completes
        send_byte(HEAD_FIRST);
        send_byte(HEAD_SECOND);
        send_byte(8'h05);
        send_byte(8'h00);
        send_byte(8'hFF);
        // shortest frame
        send_byte(HEAD_FIRST);
        send_byte(HEAD_SECOND);
        send_byte(8'h01);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h00);
        // longest frame with the top function code
        send_frame(8'(FUNC_END - 1), 8'(LENGTH_LIMIT - 1));

        // random traffic under each idling mix
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 48; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 48; end
                default: begin gap_pct = 38; stall_pct = 38; end
            endcase
            while (bytes_sent < (p + 1) * ITEM_TARGET / 4)
                send_random_item();
            in_valid <= 1'b0;
            wait_for_drain();
            @(posedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_beats.size() == 0)
            $display("header_length_frame_parser regression: pass");
        else
            $display("header_length_frame_parser regression: fail");
        $finish;
    end

endmodule
